// ===== src/ltsm_pkg.sv =====
// Shared constants, item types and helpers for the literal text search matcher.
package ltsm_pkg;

	localparam int PATTERN_MAX = 128;
	localparam int LEN_W       = $clog2(PATTERN_MAX + 1);

	localparam logic [1:0] CMD_CLEAR  = 2'd0;
	localparam logic [1:0] CMD_APPEND = 2'd1;
	localparam logic [1:0] CMD_TEXT   = 2'd2;

	localparam logic [1:0] REG_EXACT_CASE   = 2'd0;
	localparam logic [1:0] REG_SCAN_REVERSE = 2'd1;
	localparam logic [1:0] REG_REPORT_START = 2'd2;

	typedef struct packed {
		logic [1:0] cmd;
		logic [7:0] data_byte;
	} text_item_t;

	typedef struct packed {
		logic        hit;
		logic [31:0] match_position;
		logic [7:0]  pattern_length;
		logic        status;
	} result_item_t;

	// Broadcast from the top level to every cell of the row.
	typedef struct packed {
		logic             clr_bits;     // clear partial bits (clear or append)
		logic             load;         // store a pattern byte
		logic             text;         // shift in one text byte
		logic [7:0]       load_byte;
		logic [7:0]       text_folded;
		logic             exact_case;
		logic             scan_reverse;
		logic [LEN_W-1:0] len;
	} cell_ctl_t;

	function automatic logic [7:0] fold_byte(input logic [7:0] b, input logic exact);
		if (!exact && b >= 8'h61 && b <= 8'h7A)
			return b ^ 8'h20;
		return b;
	endfunction

endpackage

// ===== src/ltsm_cell.sv =====
// One match cell: a pattern byte in load order, one in reversed order, and a partial bit.
module ltsm_cell
	import ltsm_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic [LEN_W-1:0] idx,
	input  cell_ctl_t        ctl,
	input  logic             hit,
	input  logic [7:0]       rev_in,
	input  logic             bit_in,
	output logic [7:0]       rev_q,
	output logic             bit_q,
	output logic             hit_term
);

	logic [7:0] fwd_q;
	logic [7:0] pat;
	logic       active;
	logic       last;
	logic       bit_new;

	assign active   = idx < ctl.len;
	assign last     = (idx + LEN_W'(1)) == ctl.len;
	assign pat      = fold_byte(ctl.scan_reverse ? rev_q : fwd_q, ctl.exact_case);
	assign bit_new  = active && bit_in && (pat == ctl.text_folded);
	assign hit_term = ctl.text && last && bit_new;

	// Forward copy is written at the current length; reversed copy shifts on every load.
	always_ff @(posedge clk) begin
		if (ctl.load) begin
			rev_q <= rev_in;
			if (idx == ctl.len)
				fwd_q <= ctl.load_byte;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bit_q <= 1'b0;
		end else if (ctl.clr_bits || (ctl.text && hit)) begin
			bit_q <= 1'b0;
		end else if (ctl.text) begin
			bit_q <= bit_new;
		end
	end

endmodule

// ===== src/literal_text_search_matcher_core.sv =====
// Top level of the literal text search matcher: cell row, counters and output buffer.
//
// Items arrive on the text channel (text_valid / text_stall), each carrying a
// command and a byte: clear, append a pattern byte, or a text byte. Every
// accepted item gives exactly one result on the result channel
// (result_valid / result_stall): hit flag, match position, stored pattern
// length and a store-full status.
// A row of PATTERN_MAX cells holds the pattern and the shift-and partial bits;
// each text byte moves every partial bit one cell along.
// Each result is registered. Throughput is one item per cycle while text_stall
// is low, as the cell row and the hit OR update together.
// A result register plus a skid register sit on the output, so an item is still taken
// while one result waits; text_stall rises only when both hold results. cfg_ready is
// always high; the user must see that registers are written only while idle, as the
// block does not enforce it. Reset clears the length, the text counter, all partial
// bits, the registers and the output buffer; pattern bytes are undefined until loaded.
module literal_text_search_matcher_core
	import ltsm_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	input  logic         text_valid,
	output logic         text_stall,
	input  text_item_t   text_item,
	output logic         result_valid,
	input  logic         result_stall,
	output result_item_t result_item,
	input  logic         cfg_valid,
	output logic         cfg_ready,
	input  logic [1:0]   cfg_index,
	input  logic         cfg_data
);

	logic             exact_case_q;
	logic             scan_reverse_q;
	logic             report_start_q;
	logic [LEN_W-1:0] len_q;
	logic [31:0]      count_q;

	logic             accept;
	logic             is_clear;
	logic             is_append;
	logic             is_text;
	logic             full;
	cell_ctl_t        ctl;

	logic [7:0] rev_chain [PATTERN_MAX+1];
	logic       bit_chain [PATTERN_MAX+1];
	logic [PATTERN_MAX-1:0] hit_terms;
	logic       hit;

	logic [31:0]  len32;
	logic [31:0]  count_next;
	result_item_t res;

	logic         out_v_q;
	logic         skid_v_q;
	result_item_t out_q;
	result_item_t skid_q;
	logic         take;
	logic         load_out;
	logic         load_skid;
	logic         pop;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			exact_case_q   <= 1'b0;
			scan_reverse_q <= 1'b0;
			report_start_q <= 1'b0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_EXACT_CASE:   exact_case_q   <= cfg_data;
				REG_SCAN_REVERSE: scan_reverse_q <= cfg_data;
				REG_REPORT_START: report_start_q <= cfg_data;
				default: ;
			endcase
		end
	end

	assign accept    = text_valid && !text_stall;
	assign is_clear  = accept && (text_item.cmd == CMD_CLEAR);
	assign is_text   = accept && (text_item.cmd == CMD_TEXT);
	assign full      = len_q == LEN_W'(PATTERN_MAX);
	assign is_append = accept && (text_item.cmd == CMD_APPEND) && !full;

	always_comb begin
		ctl.clr_bits     = is_clear || is_append;
		ctl.load         = is_append;
		ctl.text         = is_text;
		ctl.load_byte    = text_item.data_byte;
		ctl.text_folded  = fold_byte(text_item.data_byte, exact_case_q);
		ctl.exact_case   = exact_case_q;
		ctl.scan_reverse = scan_reverse_q;
		ctl.len          = len_q;
	end

	assign rev_chain[0] = text_item.data_byte;
	assign bit_chain[0] = 1'b1;

	for (genvar g = 0; g < PATTERN_MAX; g++) begin : g_cell
		ltsm_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.idx      (LEN_W'(g)),
			.ctl      (ctl),
			.hit      (hit),
			.rev_in   (rev_chain[g]),
			.bit_in   (bit_chain[g]),
			.rev_q    (rev_chain[g+1]),
			.bit_q    (bit_chain[g+1]),
			.hit_term (hit_terms[g])
		);
	end

	assign hit = |hit_terms;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q   <= '0;
			count_q <= '0;
		end else if (is_clear) begin
			len_q   <= '0;
			count_q <= '0;
		end else begin
			if (is_append)
				len_q <= len_q + LEN_W'(1);
			if (is_text)
				count_q <= count_next;
		end
	end

	assign len32      = 32'(len_q);
	assign count_next = count_q + 32'd1;

	// Length shown after this item: cleared, grown by one, or unchanged.
	always_comb begin
		logic [31:0] len_after;
		len_after = is_clear ? 32'd0 : (is_append ? len32 + 32'd1 : len32);
		res.hit            = hit;
		res.match_position = !hit ? 32'd0 :
		                     (report_start_q ? count_next - len32 : count_next);
		res.pattern_length = len_after[7:0];
		res.status         = (text_item.cmd == CMD_APPEND) && full;
	end

	// Output register with a skid register behind it.
	assign text_stall   = skid_v_q;
	assign take         = out_v_q && !result_stall;
	assign pop          = take && skid_v_q;
	assign load_out     = accept && (!out_v_q || take);
	assign load_skid    = accept && out_v_q && !take;
	assign result_valid = out_v_q;
	assign result_item  = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q  <= 1'b0;
			skid_v_q <= 1'b0;
		end else begin
			if (pop || load_out)
				out_v_q <= 1'b1;
			else if (take)
				out_v_q <= 1'b0;
			if (load_skid)
				skid_v_q <= 1'b1;
			else if (pop)
				skid_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pop)
			out_q <= skid_q;
		else if (load_out)
			out_q <= res;
		if (load_skid)
			skid_q <= res;
	end

endmodule

// ===== verif/literal_text_search_matcher_core_test.sv =====
// Self-checking testbench for the literal text search matcher core.
module literal_text_search_matcher_core_test;
	import ltsm_pkg::*;

	localparam logic [1:0] CMD_NONE    = 2'd3;
	localparam logic [7:0] NL          = 8'h0A;
	localparam logic [7:0] NUL         = 8'h00;
	localparam int         CYCLE_LIMIT = 400000;
	localparam int         SEG_ITEMS   = 64;
	localparam int         MAX_REPORTS = 10;
	localparam logic [7:0] COMMON_BYTES [8] = '{8'h61, 8'h41, 8'h62, 8'h42,
		8'h7A, 8'h5A, NL, NUL};

	logic         clk          = 1'b0;
	logic         arst_n       = 1'b0;
	logic         text_valid   = 1'b0;
	logic         text_stall;
	text_item_t   text_item    = '0;
	logic         result_valid;
	logic         result_stall = 1'b0;
	result_item_t result_item;
	logic         cfg_valid    = 1'b0;
	logic         cfg_ready;
	logic [1:0]   cfg_index    = REG_EXACT_CASE;
	logic         cfg_data     = 1'b0;

	literal_text_search_matcher_core i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.text_valid   (text_valid),
		.text_stall   (text_stall),
		.text_item    (text_item),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result_item  (result_item),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	// Register copies and matcher state of the predictor
	logic                   exact_cfg   = 1'b0;
	logic                   reverse_cfg = 1'b0;
	logic                   start_cfg   = 1'b0;
	logic [7:0]             pat_bytes [PATTERN_MAX];
	int                     pat_len     = 0;
	logic [PATTERN_MAX-1:0] prefix_live = '0;
	logic [31:0]            text_count  = '0;

	text_item_t   pending_items [$];
	result_item_t expected_results [$];
	logic [7:0]   gen_pattern [$];
	result_item_t want_item;

	int queued_count   = 0;
	int accepted_count = 0;
	int rand_items     = 0;
	int err_count      = 0;
	int results_seen   = 0;
	int hits_seen      = 0;
	int full_seen      = 0;
	int cycle_count    = 0;
	int send_idle_pct  = 0;
	int stall_pct      = 0;

	initial begin
		forever #5 clk = ~clk;
	end

	function automatic logic [7:0] cmp_key(input logic [7:0] b);
		if (!exact_cfg && b >= 8'h61 && b <= 8'h7A)
			return b & 8'hDF;
		return b;
	endfunction

	// Advance the matcher by one item and queue the result it should give.
	function automatic void predict_item(input text_item_t it);
		result_item_t           r;
		logic [7:0]             c;
		logic [7:0]             p;
		logic [PATTERN_MAX-1:0] nxt;
		r = '0;
		case (it.cmd)
			CMD_CLEAR: begin
				pat_len     = 0;
				prefix_live = '0;
				text_count  = '0;
			end
			CMD_APPEND: begin
				if (pat_len >= PATTERN_MAX) begin
					r.status = 1'b1;
				end else begin
					pat_bytes[pat_len] = it.data_byte;
					pat_len++;
					prefix_live = '0;
				end
			end
			CMD_TEXT: begin
				c   = cmp_key(it.data_byte);
				nxt = '0;
				for (int k = 0; k < pat_len; k++) begin
					p = reverse_cfg ? pat_bytes[pat_len - 1 - k] : pat_bytes[k];
					if (cmp_key(p) == c)
						nxt[k] = (k == 0) ? 1'b1 : prefix_live[k - 1];
				end
				prefix_live = nxt;
				text_count  = text_count + 32'd1;
				if (pat_len > 0 && prefix_live[pat_len - 1]) begin
					r.hit            = 1'b1;
					r.match_position = start_cfg ? text_count - 32'(pat_len) : text_count;
					prefix_live      = '0;
				end
			end
			default: ;
		endcase
		r.pattern_length = 8'(pat_len);
		expected_results.push_back(r);
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			text_valid <= 1'b0;
		end else begin
			if (text_valid && !text_stall) begin
				predict_item(text_item);
				accepted_count++;
			end
			// hold a stalled item, otherwise offer the next one or idle
			if (!text_valid || !text_stall) begin
				if (pending_items.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
					text_item  <= pending_items.pop_front();
					text_valid <= 1'b1;
				end else begin
					text_valid <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_stall <= 1'b0;
		end else begin
			if (result_valid && !result_stall) begin
				results_seen++;
				if (result_item.hit)
					hits_seen++;
				if (result_item.status)
					full_seen++;
				if (expected_results.size() == 0) begin
					err_count++;
					if (err_count <= MAX_REPORTS)
						$display("unexpected result: hit=%0d pos=%0d len=%0d status=%0d",
							result_item.hit, result_item.match_position,
							result_item.pattern_length, result_item.status);
				end else begin
					want_item = expected_results.pop_front();
					if (result_item.hit !== want_item.hit ||
							result_item.match_position !== want_item.match_position ||
							result_item.pattern_length !== want_item.pattern_length ||
							result_item.status !== want_item.status) begin
						err_count++;
						if (err_count <= MAX_REPORTS) begin
							$display("result %0d: expected hit=%0d pos=%0d len=%0d status=%0d",
								results_seen, want_item.hit, want_item.match_position,
								want_item.pattern_length, want_item.status);
							$display("  got hit=%0d pos=%0d len=%0d status=%0d",
								result_item.hit, result_item.match_position,
								result_item.pattern_length, result_item.status);
						end
					end
				end
			end
			result_stall <= ($urandom_range(0, 99) < stall_pct);
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycle_count);
			$display("DONE: errors detected");
			$finish;
		end
	end

	task automatic push_item(input logic [1:0] cmd, input logic [7:0] b);
		text_item_t it;
		it.cmd       = cmd;
		it.data_byte = b;
		pending_items.push_back(it);
		queued_count++;
		if (cmd != CMD_NONE)
			rand_items++;
		// track the stored pattern so text can be built around it
		if (cmd == CMD_CLEAR)
			gen_pattern.delete();
		else if (cmd == CMD_APPEND && gen_pattern.size() < PATTERN_MAX)
			gen_pattern.push_back(b);
	endtask

	function automatic logic [7:0] pick_byte();
		if ($urandom_range(0, 1))
			return COMMON_BYTES[$urandom_range(0, 7)];
		return 8'($urandom_range(0, 255));
	endfunction

	function automatic logic [7:0] vary_case(input logic [7:0] b);
		if (((b >= 8'h61 && b <= 8'h7A) || (b >= 8'h41 && b <= 8'h5A)) && $urandom_range(0, 1))
			return b ^ 8'h20;
		return b;
	endfunction

	// Feed the stored pattern as text in matching order, clean or lightly damaged.
	task automatic embed_pattern(input bit exact_copy);
		int         n;
		logic [7:0] b;
		n = gen_pattern.size();
		for (int k = 0; k < n; k++) begin
			b = reverse_cfg ? gen_pattern[n - 1 - k] : gen_pattern[k];
			if (!exact_copy) begin
				if ($urandom_range(0, 19) == 0)
					b = pick_byte();
				b = vary_case(b);
			end
			push_item(CMD_TEXT, b);
		end
	endtask

	task automatic gen_sequence(input bit long_pat, input bit text_only);
		int plen;
		int chunks;
		int r;
		if (!text_only) begin
			if (long_pat || gen_pattern.size() > 8 || $urandom_range(0, 3) != 0)
				push_item(CMD_CLEAR, 8'($urandom));
			plen = long_pat ? $urandom_range(PATTERN_MAX + 1, PATTERN_MAX + 3) :
				$urandom_range(0, 5);
			repeat (plen) push_item(CMD_APPEND, pick_byte());
		end
		if (long_pat) begin
			embed_pattern(1'b1);
			push_item(CMD_TEXT, pick_byte());
			embed_pattern(1'b1);
		end
		chunks = $urandom_range(2, 6);
		repeat (chunks) begin
			r = $urandom_range(0, 99);
			if (r < 55)
				embed_pattern($urandom_range(0, 1));
			else if (r < 90)
				repeat ($urandom_range(1, 4)) push_item(CMD_TEXT, pick_byte());
			else if (r < 95)
				push_item(CMD_NONE, 8'($urandom));
			else if (r < 98)
				push_item(CMD_APPEND, pick_byte());
			else
				push_item(CMD_CLEAR, 8'($urandom));
		end
	endtask

	task automatic put_reg(input logic [1:0] idx, input logic val);
		cfg_index <= idx;
		cfg_data  <= val;
		cfg_valid <= 1'b1;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		case (idx)
			REG_EXACT_CASE:   exact_cfg = val;
			REG_SCAN_REVERSE: reverse_cfg = val;
			REG_REPORT_START: start_cfg = val;
			default: ;
		endcase
	endtask

	task automatic wait_idle();
		while (accepted_count != queued_count || expected_results.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	initial begin
		logic [2:0] regs;
		int         s;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// empty pattern, unused command, folded hit with a zero byte, newline in pattern
		push_item(CMD_TEXT, 8'h61);
		push_item(CMD_NONE, 8'hFF);
		push_item(CMD_APPEND, 8'h61);
		push_item(CMD_APPEND, NUL);
		push_item(CMD_APPEND, 8'h62);
		push_item(CMD_TEXT, 8'h41);
		push_item(CMD_TEXT, NUL);
		push_item(CMD_TEXT, 8'h42);
		push_item(CMD_APPEND, NL);
		push_item(CMD_TEXT, 8'h61);
		push_item(CMD_TEXT, NUL);
		push_item(CMD_TEXT, 8'h62);
		push_item(CMD_TEXT, NL);
		push_item(CMD_TEXT, 8'hFF);
		// letter range edges: z folds, brace and backquote do not
		push_item(CMD_CLEAR, 8'hFF);
		push_item(CMD_APPEND, 8'h7A);
		push_item(CMD_APPEND, 8'h7B);
		push_item(CMD_TEXT, 8'h5A);
		push_item(CMD_TEXT, 8'h7B);
		push_item(CMD_TEXT, 8'h5A);
		push_item(CMD_TEXT, 8'h5B);
		push_item(CMD_CLEAR, NUL);
		push_item(CMD_APPEND, 8'h40);
		push_item(CMD_TEXT, 8'h60);
		push_item(CMD_TEXT, 8'h40);
		push_item(CMD_APPEND, 8'hFF);
		push_item(CMD_TEXT, 8'hFF);
		wait_idle();

		for (s = 0; s < 8; s++) begin
			case (s / 2)
				0: begin
					send_idle_pct = 0;
					stall_pct     = 0;
				end
				1: begin
					send_idle_pct = 75;
					stall_pct     = 0;
				end
				2: begin
					send_idle_pct = 0;
					stall_pct     = 75;
				end
				default: begin
					send_idle_pct = 8;
					stall_pct     = 8;
				end
			endcase
			regs = (s == 0) ? 3'b111 : (s == 1) ? 3'b000 : 3'($urandom);
			put_reg(REG_EXACT_CASE, regs[0]);
			put_reg(REG_SCAN_REVERSE, regs[1]);
			put_reg(REG_REPORT_START, regs[2]);
			cfg_valid <= 1'b0;
			rand_items = 0;
			// keep streaming text so partial matches cross the register change
			gen_sequence(1'b0, 1'b1);
			if (s == 1)
				gen_sequence(1'b1, 1'b0);
			while (rand_items < SEG_ITEMS)
				gen_sequence(1'b0, 1'b0);
			wait_idle();
		end

		err_count += expected_results.size();
		$display("covered %0d items over nine register phases and four idle patterns",
			accepted_count);
		$display("%0d results checked: %0d hits, %0d appends dropped on a full store",
			results_seen, hits_seen, full_seen);
		if (err_count == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule
